[hw/rtl/tcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triple coincidence builder package
// Shared widths, register codes, request types and time helpers.
// ----------------------------------------------------------------------------
package tcb_pkg;

  // Field widths.
  localparam int unsigned ENERGY_W  = 16;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned BIN_W     = 11;
  localparam int unsigned RAW_BIN_W = ENERGY_W - 4;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] TIME_WINDOW_RST = 16'd18;
  localparam logic [CFG_W-1:0] ENERGY_LOW_RST  = 16'd320;
  localparam logic [CFG_W-1:0] ENERGY_HIGH_RST = 16'd32000;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_WINDOW = 2'd0,
    CFG_ENERGY_LOW  = 2'd1,
    CFG_ENERGY_HIGH = 2'd2
  } cfg_idx_e;

  // Input request: one detector hit.
  typedef struct packed {
    logic [ENERGY_W-1:0] hit_energy;
    logic [TIME_W-1:0]   hit_time;
    logic                event_start;
  } hit_req_t;

  // Result request: one unordered triple of energy bins.
  typedef struct packed {
    logic [BIN_W-1:0] bin_first;
    logic [BIN_W-1:0] bin_second;
    logic [BIN_W-1:0] bin_newest;
    logic             last_triple;
  } triple_t;

  // Classified hit passed from the front end to the pair walker.
  typedef struct packed {
    logic              event_start;
    logic              hit_ok;
    logic [BIN_W-1:0]  bin;
    logic [TIME_W-1:0] hit_time;
  } cmd_t;

  // Absolute difference of two timestamps.
  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] x,
                                                 input logic [TIME_W-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

endpackage

[hw/rtl/tcb_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module tcb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[hw/rtl/tcb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triple coincidence builder front end
// Holds the configuration registers, classifies incoming hits against the
// energy window and queues them for the pair walker.
// ----------------------------------------------------------------------------
module tcb_front #(
  parameter int unsigned NumBins = 2000
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  input  tcb_pkg::hit_req_t                hit_i,
  output logic                             full,
  input  logic                             cfg_we_i,
  input  logic [tcb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tcb_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic [tcb_pkg::CFG_W-1:0]        time_window_o,
  output tcb_pkg::cmd_t                    cmd_o,
  output logic                             cmd_empty_o,
  input  logic                             cmd_pop_i
);

  localparam logic [tcb_pkg::RAW_BIN_W:0] BinMax = (tcb_pkg::RAW_BIN_W + 1)'(NumBins - 1);

  logic [tcb_pkg::CFG_W-1:0]     time_window_q, energy_low_q, energy_high_q;
  logic [tcb_pkg::RAW_BIN_W-1:0] raw_bin;
  logic                          in_window, bin_ok;
  tcb_pkg::cmd_t                 cmd_in;
  logic [$bits(tcb_pkg::cmd_t)-1:0] cmd_raw;
  logic                          cmd_push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_window_q <= tcb_pkg::TIME_WINDOW_RST;
      energy_low_q  <= tcb_pkg::ENERGY_LOW_RST;
      energy_high_q <= tcb_pkg::ENERGY_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcb_pkg::CFG_TIME_WINDOW: time_window_q <= cfg_wdata_i;
        tcb_pkg::CFG_ENERGY_LOW:  energy_low_q  <= cfg_wdata_i;
        tcb_pkg::CFG_ENERGY_HIGH: energy_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign time_window_o = time_window_q;

  // Energy window and bin range check.
  assign raw_bin   = hit_i.hit_energy[tcb_pkg::ENERGY_W-1:4];
  assign in_window = (hit_i.hit_energy >= energy_low_q) &&
                     (hit_i.hit_energy <= energy_high_q);
  assign bin_ok    = ({1'b0, raw_bin} <= BinMax);

  always_comb begin
    cmd_in.event_start = hit_i.event_start;
    cmd_in.hit_ok      = in_window && bin_ok;
    cmd_in.bin         = raw_bin[tcb_pkg::BIN_W-1:0];
    cmd_in.hit_time    = hit_i.hit_time;
  end

  // A rejected hit only matters when it opens a new event.
  assign cmd_push = push && !full && (cmd_in.hit_ok || cmd_in.event_start);

  tcb_fifo #(
    .Width ($bits(tcb_pkg::cmd_t)),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = tcb_pkg::cmd_t'(cmd_raw);

endmodule

[hw/rtl/tcb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triple coincidence builder pair walker
// Keeps the hits of the current event and walks every stored pair against
// the newest hit through a read, difference and compare pipeline.
// ----------------------------------------------------------------------------
module tcb_back #(
  parameter int unsigned MaxHits = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcb_pkg::cmd_t               cmd_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  input  logic [tcb_pkg::CFG_W-1:0]   time_window_i,
  output tcb_pkg::triple_t            res_o,
  output logic                        res_push_o,
  input  logic                        res_full_i
);

  localparam int unsigned IdxW = $clog2(MaxHits);
  localparam int unsigned CntW = $clog2(MaxHits + 1);
  localparam int unsigned TW   = tcb_pkg::TIME_W;
  localparam int unsigned BW   = tcb_pkg::BIN_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_base;
  logic [CntW-1:0] a_q, a_d, b_q, b_d;
  logic [TW-1:0]   new_time_q, new_time_d;
  logic [BW-1:0]   new_bin_q, new_bin_d;

  // Hit store, two registered read ports.
  logic [TW-1:0] time_mem [MaxHits];
  logic [BW-1:0] bin_mem  [MaxHits];
  logic [TW-1:0] rd_ta_q, rd_tb_q;
  logic [BW-1:0] rd_ba_q, rd_bb_q;
  logic          s1_vld_q;

  // Difference stage.
  logic [TW-1:0] d_an_q, d_bn_q, d_ab_q;
  logic [BW-1:0] s2_ba_q, s2_bb_q;
  logic          s2_vld_q;

  // Pending triple, held until it is known whether another follows.
  logic [BW-1:0] pend_ba_q, pend_bb_q;
  logic          pend_vld_q, pend_vld_d;

  logic          adv, pair_live, issue, match, mid_push, fin_done, store_we;
  logic [TW-1:0] window;

  assign adv       = !res_full_i;
  assign pair_live = (b_q < cnt_q);
  assign issue     = (state_q == ST_WALK) && pair_live && adv;
  assign window    = TW'(time_window_i);
  assign match     = s2_vld_q && (d_an_q <= window) && (d_bn_q <= window) &&
                     (d_ab_q <= window);
  assign mid_push  = adv && match && pend_vld_q;
  assign fin_done  = (state_q == ST_FINISH) && !(pend_vld_q && res_full_i);
  assign store_we  = fin_done;
  assign cmd_pop_o = (state_q == ST_IDLE) && !cmd_empty_i;
  assign cnt_base  = cmd_i.event_start ? '0 : cnt_q;

  // Sequencer and pair index generation.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    a_d        = a_q;
    b_d        = b_q;
    new_time_d = new_time_q;
    new_bin_d  = new_bin_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          cnt_d = cnt_base;
          if (cmd_i.hit_ok && (cnt_base < CntW'(MaxHits))) begin
            new_time_d = cmd_i.hit_time;
            new_bin_d  = cmd_i.bin;
            a_d        = '0;
            b_d        = CntW'(1);
            state_d    = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!pair_live) begin
          state_d = ST_DRAIN;
        end else if (issue) begin
          if ((b_q + CntW'(1)) < cnt_q) begin
            b_d = b_q + CntW'(1);
          end else begin
            a_d = a_q + CntW'(1);
            b_d = a_q + CntW'(2);
          end
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_done) begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Pending triple bookkeeping.
  always_comb begin
    pend_vld_d = pend_vld_q;
    if (adv && match) begin
      pend_vld_d = 1'b1;
    end else if (fin_done) begin
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      a_q        <= '0;
      b_q        <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      a_q        <= a_d;
      b_q        <= b_d;
      pend_vld_q <= pend_vld_d;
      if (adv) begin
        s1_vld_q <= issue;
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  // Store write and pair reads.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      time_mem[cnt_q[IdxW-1:0]] <= new_time_q;
      bin_mem[cnt_q[IdxW-1:0]]  <= new_bin_q;
    end
    if (adv) begin
      rd_ta_q <= time_mem[a_q[IdxW-1:0]];
      rd_tb_q <= time_mem[b_q[IdxW-1:0]];
      rd_ba_q <= bin_mem[a_q[IdxW-1:0]];
      rd_bb_q <= bin_mem[b_q[IdxW-1:0]];
    end
  end

  // Payload registers of the walk pipeline.
  always_ff @(posedge clk_i) begin
    new_time_q <= new_time_d;
    new_bin_q  <= new_bin_d;
    if (adv) begin
      d_an_q  <= tcb_pkg::abs_diff(rd_ta_q, new_time_q);
      d_bn_q  <= tcb_pkg::abs_diff(rd_tb_q, new_time_q);
      d_ab_q  <= tcb_pkg::abs_diff(rd_ta_q, rd_tb_q);
      s2_ba_q <= rd_ba_q;
      s2_bb_q <= rd_bb_q;
      if (match) begin
        pend_ba_q <= s2_ba_q;
        pend_bb_q <= s2_bb_q;
      end
    end
  end

  // A triple leaves once a later one appears or the walk has ended.
  assign res_push_o = mid_push || ((state_q == ST_FINISH) && pend_vld_q && !res_full_i);

  always_comb begin
    res_o.bin_first   = pend_ba_q;
    res_o.bin_second  = pend_bb_q;
    res_o.bin_newest  = new_bin_q;
    res_o.last_triple = (state_q == ST_FINISH);
  end

`ifndef SYNTHESIS
  // The store never holds more hits than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(MaxHits))
    else $error("tcb_back: stored hit count above capacity");

  // Results are only pushed while the result queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push_o |-> !res_full_i)
    else $error("tcb_back: push into a full result queue");

  // Every issued pair has its first index below its second.
  assert property (@(posedge clk_i) disable iff (!rst_ni) issue |-> (a_q < b_q))
    else $error("tcb_back: pair indices out of order");

  // The walk pipeline is empty before the newest hit is stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (!s1_vld_q && !s2_vld_q))
    else $error("tcb_back: store written while pairs are in flight");

  // A triple flagged as last leaves only at the end of a walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last_triple) |=> (state_q == ST_IDLE))
    else $error("tcb_back: last triple outside the end of a walk");
`endif

endmodule

[hw/rtl/triple_coincidence_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triple coincidence builder
// Builds unordered triples of energy bins from time-coincident hits of one
// event for a downstream three-dimensional histogram filler.
// ----------------------------------------------------------------------------
// Hits enter through a queue-style port and are classified at once against
// the energy window and bin range; a hit that fails either check and does not
// open an event is dropped. For an accepted hit the pair walker issues one
// stored pair per cycle while the result queue has room, from the two read
// ports of the hit store, then a difference stage and a compare stage check
// the three time gaps, and the newest hit is written to the store at the end.
// A two-entry command queue lets new hits be taken while a walk is in
// progress, and a four-entry result queue holds finished triples; the walk
// pauses while that queue is full. Configuration writes take effect on the
// next cycle and should only be made while the block is idle.
module triple_coincidence_builder_unit #(
  parameter int unsigned MAX_HITS = 8,
  parameter int unsigned NUM_BINS = 2000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  tcb_pkg::hit_req_t             hit_i,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output tcb_pkg::triple_t              triple_o,
  input  logic                          cfg_we_i,
  input  logic [tcb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcb_pkg::CFG_W-1:0]     cfg_wdata_i
);

  tcb_pkg::cmd_t                  cmd;
  logic                           cmd_empty, cmd_pop;
  logic [tcb_pkg::CFG_W-1:0]      time_window;
  tcb_pkg::triple_t               res;
  logic                           res_push, res_full;
  logic [$bits(tcb_pkg::triple_t)-1:0] res_raw;

  // Classification and command queue.
  tcb_front #(
    .NumBins (NUM_BINS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .hit_i         (hit_i),
    .full          (full),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .time_window_o (time_window),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty),
    .cmd_pop_i     (cmd_pop)
  );

  // Hit store and pair walk.
  tcb_back #(
    .MaxHits (MAX_HITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .time_window_i (time_window),
    .res_o         (res),
    .res_push_o    (res_push),
    .res_full_i    (res_full)
  );

  // Result queue toward the histogram filler.
  tcb_fifo #(
    .Width ($bits(tcb_pkg::triple_t)),
    .Depth (4)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_raw),
    .empty_o (empty)
  );

  assign triple_o = tcb_pkg::triple_t'(res_raw);

endmodule
